// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the color ramp rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SFFR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SFFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sffr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_pkg
// widths, command codes and shared types of the flash and fade color ramp
// ----------------------------------------------------------------------------
package sffr_pkg;

  localparam int CMD_W      = 2;
  localparam int COLOR_W    = 8;
  localparam int DUR_W      = 16;
  localparam int PRIO_W     = 8;
  localparam int SORT_W     = 8;
  localparam int FRAC_SHIFT = 16;
  localparam int LEVEL_W    = COLOR_W + FRAC_SHIFT;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = $clog2(NUM_CH);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 24'hff0000;
  localparam logic [PRIO_W-1:0]  TOP_PRIORITY = 8'd255;

  // one quotient bit per cycle
  localparam int DIV_STEPS = LEVEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_RESET = 2'd0;
  localparam cmd_t CMD_FLASH = 2'd1;
  localparam cmd_t CMD_FADE  = 2'd2;
  localparam cmd_t CMD_TICK  = 2'd3;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] dividend;
    logic [DUR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/sffr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_in_if / sffr_out_if
// valid/ready channels for commands and ramp results
// ----------------------------------------------------------------------------
interface sffr_in_if import sffr_pkg::*; ;
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [COLOR_W-1:0]  red_in;
  logic [COLOR_W-1:0]  green_in;
  logic [COLOR_W-1:0]  blue_in;
  logic [DUR_W-1:0]    duration;
  logic [PRIO_W-1:0]   priority_in;
  logic [SORT_W-1:0]   sort_in;

  modport source (
    output valid, cmd, red_in, green_in, blue_in, duration, priority_in, sort_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, red_in, green_in, blue_in, duration, priority_in, sort_in,
    output ready
  );
endinterface

interface sffr_out_if import sffr_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  logic                fade_done;
  logic [SORT_W-1:0]   sort_out;
  logic [PRIO_W-1:0]   priority_out;

  modport source (
    output valid, red_level, green_level, blue_level, fade_done, sort_out, priority_out,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level, fade_done, sort_out, priority_out,
    output ready
  );
endinterface

// ===== rtl/sffr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_div
// restoring divider, 24-bit dividend by nonzero 16-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sffr_div import sffr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DUR_W-1:0]     rem_r, rem_nxt;
  logic [LEVEL_W-1:0]   quo_r, quo_nxt;
  logic [DUR_W-1:0]     dvs_r, dvs_nxt;

  logic [DUR_W:0] trial;
  logic [DUR_W:0] diff;
  logic           fits;

  // partial remainder stays below the divisor, so 16 bits hold it
  assign trial = {rem_r, quo_r[LEVEL_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      quo_nxt = {quo_r[LEVEL_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `SFFR_ASSERT_NEXT(a_start_busy, req.start, busy_r && cnt_r == DIV_CNT_W'(DIV_STEPS), "divider did not start")
  `SFFR_ASSERT_NEXT(a_last_step_done, busy_r && !req.start && cnt_r == DIV_CNT_W'(1), done_r && !busy_r, "divider missed its end")
  `SFFR_ASSERT_NOW(a_done_idle, done_r, !busy_r, "done while still busy")

endmodule

// ===== rtl/screen_flash_fade_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_flash_fade_ramp_top
// screen flash and fade color ramp in 8.16 fixed point with a shared divider
// ----------------------------------------------------------------------------
//  channel  dir  modport  carries
//  in_ch    in   sink     cmd, red/green/blue_in, duration, priority_in, sort_in
//  out_ch   out  source   red/green/blue_level, fade_done, sort_out, priority_out
//
//  one result per command; in_ch.ready is high only while the sequencer idles
//  flash: three divisions, one per channel in turn
//  fade with nonzero duration: one division shared by all channels; others none
//  both use the shared restoring divider; ticks add/subtract with no division
//  a held result in out_ch stalls the sequencer before its next result
//  synchronous active-low reset clears levels, steps, counters, flags and valid to zero
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module screen_flash_fade_ramp_top import sffr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sffr_in_if.sink   in_ch,
  sffr_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE      = 2'd0;
  localparam logic [1:0] S_DIV_START = 2'd1;
  localparam logic [1:0] S_DIV_WAIT  = 2'd2;
  localparam logic [1:0] S_PUSH      = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic               fade_div_r, fade_div_nxt;
  logic [DUR_W-1:0]   dvs_r, dvs_nxt;

  logic [LEVEL_W-1:0] level_r [NUM_CH];
  logic [LEVEL_W-1:0] level_nxt [NUM_CH];
  logic [LEVEL_W-1:0] step_r [NUM_CH];
  logic [LEVEL_W-1:0] step_nxt [NUM_CH];
  logic [DUR_W-1:0]   flash_cnt_r, flash_cnt_nxt;
  logic [DUR_W-1:0]   fade_cnt_r, fade_cnt_nxt;
  logic               fade_mode_r, fade_mode_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  logic [SORT_W-1:0]  sort_r, sort_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_red_r, out_red_nxt;
  logic [LEVEL_W-1:0] out_green_r, out_green_nxt;
  logic [LEVEL_W-1:0] out_blue_r, out_blue_nxt;
  logic               out_done_r, out_done_nxt;
  logic [SORT_W-1:0]  out_sort_r, out_sort_nxt;
  logic [PRIO_W-1:0]  out_prio_r, out_prio_nxt;

  logic               in_acc;
  logic [COLOR_W-1:0] color_in [NUM_CH];
  logic [DUR_W-1:0]   flash_dec;
  logic [DUR_W-1:0]   fade_dec;
  logic [LEVEL_W:0]   sum [NUM_CH];

  div_req_t div_req;
  div_rsp_t div_rsp;

  sffr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign color_in[0] = in_ch.red_in;
  assign color_in[1] = in_ch.green_in;
  assign color_in[2] = in_ch.blue_in;

  assign flash_dec = flash_cnt_r - 1'b1;
  assign fade_dec  = fade_cnt_r - 1'b1;

  // flash steps divide each loaded level, fade divides full white
  assign div_req.start    = (state_r == S_DIV_START);
  assign div_req.dividend = fade_div_r ? FULL_LEVEL : level_r[ch_r];
  assign div_req.divisor  = dvs_r;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = {1'b0, level_r[i]} + {1'b0, step_r[0]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    fade_div_nxt  = fade_div_r;
    dvs_nxt       = dvs_r;
    level_nxt     = level_r;
    step_nxt      = step_r;
    flash_cnt_nxt = flash_cnt_r;
    fade_cnt_nxt  = fade_cnt_r;
    fade_mode_nxt = fade_mode_r;
    prio_nxt      = prio_r;
    sort_nxt      = sort_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_done_nxt  = out_done_r;
    out_sort_nxt  = out_sort_r;
    out_prio_nxt  = out_prio_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PUSH;
          unique case (in_ch.cmd)
            CMD_RESET: begin
              flash_cnt_nxt = '0;
              fade_cnt_nxt  = '0;
              fade_mode_nxt = 1'b0;
              prio_nxt      = '0;
            end
            CMD_FLASH: begin
              if (prio_r <= in_ch.priority_in && in_ch.duration != '0) begin
                flash_cnt_nxt = in_ch.duration;
                sort_nxt      = in_ch.sort_in;
                prio_nxt      = in_ch.priority_in;
                for (int i = 0; i < NUM_CH; i++) begin
                  level_nxt[i] = {color_in[i], {FRAC_SHIFT{1'b0}}};
                end
                dvs_nxt      = in_ch.duration;
                fade_div_nxt = 1'b0;
                ch_nxt       = '0;
                state_nxt    = S_DIV_START;
              end
            end
            CMD_FADE: begin
              fade_mode_nxt = 1'b1;
              fade_cnt_nxt  = in_ch.duration;
              prio_nxt      = TOP_PRIORITY;
              sort_nxt      = in_ch.sort_in;
              if (in_ch.duration == '0) begin
                for (int i = 0; i < NUM_CH; i++) begin
                  level_nxt[i] = FULL_LEVEL;
                  step_nxt[i]  = '0;
                end
              end else begin
                for (int i = 0; i < NUM_CH; i++) begin
                  level_nxt[i] = '0;
                end
                dvs_nxt      = in_ch.duration;
                fade_div_nxt = 1'b1;
                ch_nxt       = '0;
                state_nxt    = S_DIV_START;
              end
            end
            CMD_TICK: begin
              if (!fade_mode_r) begin
                if (flash_cnt_r != '0) begin
                  flash_cnt_nxt = flash_dec;
                  // last tick of a flash drops importance and holds levels
                  if (flash_dec == '0) begin
                    prio_nxt = '0;
                  end else begin
                    for (int i = 0; i < NUM_CH; i++) begin
                      level_nxt[i] = (step_r[i] > level_r[i]) ? '0
                                                              : level_r[i] - step_r[i];
                    end
                  end
                end
              end else if (fade_cnt_r != '0) begin
                fade_cnt_nxt = fade_dec;
                for (int i = 0; i < NUM_CH; i++) begin
                  if (fade_dec == '0) begin
                    level_nxt[i] = FULL_LEVEL;
                  end else begin
                    level_nxt[i] = (sum[i] > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                                : sum[i][LEVEL_W-1:0];
                  end
                end
              end
            end
            default: begin
              state_nxt = S_PUSH;
            end
          endcase
        end
      end
      S_DIV_START: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (fade_div_r) begin
            for (int i = 0; i < NUM_CH; i++) begin
              step_nxt[i] = div_rsp.quotient;
            end
            state_nxt = S_PUSH;
          end else begin
            step_nxt[ch_r] = div_rsp.quotient;
            if (ch_r == CH_W'(NUM_CH - 1)) begin
              state_nxt = S_PUSH;
            end else begin
              ch_nxt    = ch_r + 1'b1;
              state_nxt = S_DIV_START;
            end
          end
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = level_r[0];
          out_green_nxt = level_r[1];
          out_blue_nxt  = level_r[2];
          out_done_nxt  = (fade_cnt_r == '0);
          out_sort_nxt  = sort_r;
          out_prio_nxt  = prio_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      fade_div_r  <= 1'b0;
      flash_cnt_r <= '0;
      fade_cnt_r  <= '0;
      fade_mode_r <= 1'b0;
      prio_r      <= '0;
      sort_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        level_r[i] <= '0;
        step_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      fade_div_r  <= fade_div_nxt;
      flash_cnt_r <= flash_cnt_nxt;
      fade_cnt_r  <= fade_cnt_nxt;
      fade_mode_r <= fade_mode_nxt;
      prio_r      <= prio_nxt;
      sort_r      <= sort_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r       <= dvs_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_done_r  <= out_done_nxt;
    out_sort_r  <= out_sort_nxt;
    out_prio_r  <= out_prio_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_level    = out_red_r;
  assign out_ch.green_level  = out_green_r;
  assign out_ch.blue_level   = out_blue_r;
  assign out_ch.fade_done    = out_done_r;
  assign out_ch.sort_out     = out_sort_r;
  assign out_ch.priority_out = out_prio_r;

  `SFFR_ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE, "sequencer stayed idle after a transaction")
  `SFFR_ASSERT_NOW(a_start_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `SFFR_ASSERT_NOW(a_idle_prio, !fade_mode_r && flash_cnt_r == '0, prio_r == '0, "importance held with no ramp running")

endmodule
